// ----- hdl/ray_mesh_nearest_hit_unit_defines.svh -----
// Assertion helpers shared by the nearest hit unit.
`ifndef RAY_MESH_NEAREST_HIT_UNIT_DEFINES_SVH
`define RAY_MESH_NEAREST_HIT_UNIT_DEFINES_SVH

// Checks a property on every rising edge of aclk outside reset.
`define RMNH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define RMNH_ASSERT_IMPL(label, ante, cons, msg) \
    `RMNH_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- hdl/rmnh_pkg.sv -----
package rmnh_pkg;

    // Payload widths of the stream channels.
    localparam int IN_DATA_W  = 224;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;
    localparam int COUNT_W    = 9;

    // Arithmetic widths: coordinates, differences, cross products, dot products.
    localparam int CW = 32;
    localparam int EW = 33;
    localparam int PW = 67;
    localparam int WW = 104;

    // Quotient bits of the distance divider and the saturation value.
    localparam int QB = 31;
    localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_LOAD_VERTEX   = 2'd0,
        OP_LOAD_TRIANGLE = 2'd1,
        OP_CAST_RAY      = 2'd2,
        OP_NONE          = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef logic signed [EW-1:0] ext_t;
    typedef logic signed [PW-1:0] cross_t;
    typedef logic signed [WW-1:0] wide_t;

endpackage

// ----- hdl/ray_mesh_nearest_hit_unit.sv -----
// Nearest ray/triangle hit unit.
// The slave stream carries one command per beat, its kind in s_tuser: load a vertex, load
// a triangle, or cast a ray. Loads write the vertex or triangle store in the cycle they
// are accepted and give no result. A cast ray tests triangles 0 .. triangle_count-1, at most
// TRIANGLE_DEPTH of them, and gives exactly one result beat on the master stream: hit flag,
// nearest distance t in fixed point (saturated), and the index of the nearest triangle; ties
// keep the lower index. triangle_count is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the unit is idle, which the unit does not enforce. A ray streams
// one triangle per cycle from the triangle store into a 40 stage pipeline: store reads,
// edge setup, cross products, split dot products, sign fix, range checks and a 32 stage
// restoring divider for t. s_tready is high only while no ray is in progress. A result
// waits in the output register until taken; while it waits, loads and the next ray are
// accepted, and a following ray holds in its last state until the register is free.
// Reset (aresetn low, synchronous) clears control state and triangle_count; store contents
// are undefined until written.
`include "ray_mesh_nearest_hit_unit_defines.svh"

module ray_mesh_nearest_hit_unit #(
    parameter int VERTEX_DEPTH   = 256,
    parameter int TRIANGLE_DEPTH = 256,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rmnh_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot[7:0], pos_x[39:8], pos_y[71:40], pos_z[103:72], dir_x[135:104],
    // dir_y[167:136], dir_z[199:168], corner_first[207:200],
    // corner_second[215:208], corner_third[223:216]
    input  logic [rmnh_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  logic [rmnh_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance[31:0], nearest_triangle[39:32]
    output logic [rmnh_pkg::OUT_DATA_W-1:0]   m_tdata,
    // hit[0]
    output logic [rmnh_pkg::OUT_USER_W-1:0]   m_tuser
);
    import rmnh_pkg::*;

    localparam int VA  = $clog2(VERTEX_DEPTH);
    localparam int TA  = (TRIANGLE_DEPTH > 1) ? $clog2(TRIANGLE_DEPTH) : 1;
    localparam int TCW = $clog2(TRIANGLE_DEPTH + 1);
    localparam int XW  = WW + FRACTION_BITS + 32;
    localparam logic [31:0] MISS_DIST = ~((32'd1 << FRACTION_BITS) - 32'd1);

    // Input unpacking.
    opcode_t            in_op;
    logic [7:0]         in_slot;
    logic signed [31:0] in_pos [3];
    logic signed [31:0] in_dir [3];
    logic [23:0]        in_corners;
    logic               s_acc;

    assign in_op      = opcode_t'(s_tuser);
    assign in_slot    = s_tdata[7:0];
    assign in_pos[0]  = $signed(s_tdata[39:8]);
    assign in_pos[1]  = $signed(s_tdata[71:40]);
    assign in_pos[2]  = $signed(s_tdata[103:72]);
    assign in_dir[0]  = $signed(s_tdata[135:104]);
    assign in_dir[1]  = $signed(s_tdata[167:136]);
    assign in_dir[2]  = $signed(s_tdata[199:168]);
    assign in_corners = s_tdata[223:200];
    assign s_acc      = s_tvalid && s_tready;

    // Configuration.
    logic [COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // Stores. The vertex store is kept three times so each corner has its own read port.
    logic [95:0] vtx_mem0 [VERTEX_DEPTH];
    logic [95:0] vtx_mem1 [VERTEX_DEPTH];
    logic [95:0] vtx_mem2 [VERTEX_DEPTH];
    logic [23:0] tri_mem  [TRIANGLE_DEPTH];

    logic [16:0] slot_ext;
    logic        vtx_wr, tri_wr;

    assign slot_ext = 17'(in_slot);
    assign vtx_wr   = s_acc && (in_op == OP_LOAD_VERTEX) && (slot_ext < 17'(VERTEX_DEPTH));
    assign tri_wr   = s_acc && (in_op == OP_LOAD_TRIANGLE)
                      && (slot_ext < 17'(TRIANGLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (vtx_wr) begin
            vtx_mem0[slot_ext[VA-1:0]] <= s_tdata[103:8];
            vtx_mem1[slot_ext[VA-1:0]] <= s_tdata[103:8];
            vtx_mem2[slot_ext[VA-1:0]] <= s_tdata[103:8];
        end
        if (tri_wr) begin
            tri_mem[slot_ext[TA-1:0]] <= in_corners;
        end
    end

    // Sequencer.
    state_t             state_reg, state_next;
    logic [TCW-1:0]     iss_reg, lim_reg;
    logic [16:0]        lim_calc;
    logic signed [31:0] org_reg [3];
    logic signed [31:0] dir_reg [3];
    logic               issue, pipe_busy, out_free;
    logic               m_tvalid_reg, m_hit_reg;
    logic [31:0]        m_dist_reg;
    logic [7:0]         m_tri_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_RUN) && (iss_reg != lim_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign lim_calc = (17'(count_reg) < 17'(TRIANGLE_DEPTH)) ? 17'(count_reg)
                                                             : 17'(TRIANGLE_DEPTH);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && in_op == OP_CAST_RAY) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (iss_reg == lim_reg) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!pipe_busy) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iss_reg   <= '0;
            lim_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_acc && in_op == OP_CAST_RAY) begin
                iss_reg <= '0;
                lim_reg <= lim_calc[TCW-1:0];
            end else if (issue) begin
                iss_reg <= iss_reg + TCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && in_op == OP_CAST_RAY) begin
            for (int j = 0; j < 3; j++) begin
                org_reg[j] <= in_pos[j];
                dir_reg[j] <= in_dir[j];
            end
        end
    end

    // Stage 1: triangle store read.
    logic [23:0]   tri_rd_reg;
    logic          s1_v_reg;
    logic [TA-1:0] s1_idx_reg;

    always_ff @(posedge aclk) begin
        tri_rd_reg <= tri_mem[iss_reg[TA-1:0]];
        s1_idx_reg <= iss_reg[TA-1:0];
    end

    // Stage 2: vertex store reads; corners past the store make a miss.
    logic [16:0]   c_ext [3];
    logic          corners_ok;
    logic [95:0]   v0_reg, v1_reg, v2_reg;
    logic          s2_v_reg, s2_ok_reg;
    logic [TA-1:0] s2_idx_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_ext[j] = 17'(tri_rd_reg[8*j +: 8]);
        end
        corners_ok = (c_ext[0] < 17'(VERTEX_DEPTH)) && (c_ext[1] < 17'(VERTEX_DEPTH))
                     && (c_ext[2] < 17'(VERTEX_DEPTH));
    end

    always_ff @(posedge aclk) begin
        v0_reg     <= vtx_mem0[c_ext[0][VA-1:0]];
        v1_reg     <= vtx_mem1[c_ext[1][VA-1:0]];
        v2_reg     <= vtx_mem2[c_ext[2][VA-1:0]];
        s2_ok_reg  <= corners_ok;
        s2_idx_reg <= s1_idx_reg;
    end

    // Stage 3: edges from corner zero and the origin offset.
    ext_t          e1_reg [3];
    ext_t          e2_reg [3];
    ext_t          sv_reg [3];
    logic          s3_v_reg, s3_ok_reg;
    logic [TA-1:0] s3_idx_reg;

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            e1_reg[j] <= ext_t'($signed(v1_reg[32*j +: 32])) - ext_t'($signed(v0_reg[32*j +: 32]));
            e2_reg[j] <= ext_t'($signed(v2_reg[32*j +: 32])) - ext_t'($signed(v0_reg[32*j +: 32]));
            sv_reg[j] <= ext_t'(org_reg[j]) - ext_t'($signed(v0_reg[32*j +: 32]));
        end
        s3_ok_reg  <= s2_ok_reg;
        s3_idx_reg <= s2_idx_reg;
    end

    // Stage 4: h = dir x e2 and q = s x e1.
    ext_t               dx [3];
    logic signed [65:0] hp [6];
    logic signed [65:0] qp [6];
    cross_t             h_reg [3];
    cross_t             q_reg [3];
    ext_t               s4_e1_reg [3];
    ext_t               s4_e2_reg [3];
    ext_t               s4_s_reg [3];
    logic               s4_v_reg, s4_ok_reg;
    logic [TA-1:0]      s4_idx_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            dx[j] = ext_t'(dir_reg[j]);
        end
        hp[0] = dx[1] * e2_reg[2];
        hp[1] = dx[2] * e2_reg[1];
        hp[2] = dx[2] * e2_reg[0];
        hp[3] = dx[0] * e2_reg[2];
        hp[4] = dx[0] * e2_reg[1];
        hp[5] = dx[1] * e2_reg[0];
        qp[0] = sv_reg[1] * e1_reg[2];
        qp[1] = sv_reg[2] * e1_reg[1];
        qp[2] = sv_reg[2] * e1_reg[0];
        qp[3] = sv_reg[0] * e1_reg[2];
        qp[4] = sv_reg[0] * e1_reg[1];
        qp[5] = sv_reg[1] * e1_reg[0];
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            h_reg[j]     <= cross_t'(hp[2*j]) - cross_t'(hp[2*j+1]);
            q_reg[j]     <= cross_t'(qp[2*j]) - cross_t'(qp[2*j+1]);
            s4_e1_reg[j] <= e1_reg[j];
            s4_e2_reg[j] <= e2_reg[j];
            s4_s_reg[j]  <= sv_reg[j];
        end
        s4_ok_reg  <= s3_ok_reg;
        s4_idx_reg <= s3_idx_reg;
    end

    // Stage 5: dot product terms, each cut into a low and a high partial product.
    // Order of the dot products: det = e1.h, nu = s.h, nv = dir.q, nt = e2.q.
    ext_t               pa [4][3];
    cross_t             pb [4][3];
    logic signed [66:0] plo_reg [4][3];
    logic signed [66:0] phi_reg [4][3];
    logic               s5_v_reg, s5_ok_reg;
    logic [TA-1:0]      s5_idx_reg;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            pa[0][j] = s4_e1_reg[j];
            pb[0][j] = h_reg[j];
            pa[1][j] = s4_s_reg[j];
            pb[1][j] = h_reg[j];
            pa[2][j] = ext_t'(dir_reg[j]);
            pb[2][j] = q_reg[j];
            pa[3][j] = s4_e2_reg[j];
            pb[3][j] = q_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                plo_reg[i][j] <= pa[i][j] * $signed({1'b0, pb[i][j][32:0]});
                phi_reg[i][j] <= pa[i][j] * $signed(pb[i][j][66:33]);
            end
        end
        s5_ok_reg  <= s4_ok_reg;
        s5_idx_reg <= s4_idx_reg;
    end

    // Stage 6: partial products summed into the four dot products.
    wide_t         dot_reg [4];
    logic          s6_v_reg, s6_ok_reg;
    logic [TA-1:0] s6_idx_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            dot_reg[i] <= (wide_t'(phi_reg[i][0]) <<< 33) + wide_t'(plo_reg[i][0])
                        + (wide_t'(phi_reg[i][1]) <<< 33) + wide_t'(plo_reg[i][1])
                        + (wide_t'(phi_reg[i][2]) <<< 33) + wide_t'(plo_reg[i][2]);
        end
        s6_ok_reg  <= s5_ok_reg;
        s6_idx_reg <= s5_idx_reg;
    end

    // Stage 7: make the determinant positive; a zero determinant is a miss.
    wide_t         s7_det_reg, s7_nu_reg, s7_nv_reg, s7_nt_reg;
    logic          s7_v_reg, s7_ok_reg;
    logic [TA-1:0] s7_idx_reg;
    logic          det_neg;

    assign det_neg = dot_reg[0][WW-1];

    always_ff @(posedge aclk) begin
        s7_det_reg <= det_neg ? -dot_reg[0] : dot_reg[0];
        s7_nu_reg  <= det_neg ? -dot_reg[1] : dot_reg[1];
        s7_nv_reg  <= det_neg ? -dot_reg[2] : dot_reg[2];
        s7_nt_reg  <= det_neg ? -dot_reg[3] : dot_reg[3];
        s7_ok_reg  <= s6_ok_reg && (dot_reg[0] != '0);
        s7_idx_reg <= s6_idx_reg;
    end

    // Stage 8: barycentric and distance range checks, divider operands.
    logic          range_ok;
    wide_t         uv_sum;
    logic [XW-1:0] s8_n_reg;
    logic [WW-1:0] s8_d_reg;
    logic          s8_v_reg, s8_ok_reg;
    logic [TA-1:0] s8_idx_reg;

    assign uv_sum   = s7_nu_reg + s7_nv_reg;
    assign range_ok = !s7_nu_reg[WW-1] && !(s7_nu_reg > s7_det_reg)
                      && !s7_nv_reg[WW-1] && !(uv_sum > s7_det_reg)
                      && !s7_nt_reg[WW-1];

    always_ff @(posedge aclk) begin
        s8_n_reg   <= XW'($unsigned(s7_nt_reg)) << FRACTION_BITS;
        s8_d_reg   <= $unsigned(s7_det_reg);
        s8_ok_reg  <= s7_ok_reg && range_ok;
        s8_idx_reg <= s7_idx_reg;
    end

    // Restoring divider, one quotient bit per stage, after a saturation check.
    logic [XW-1:0] dv_r_reg   [QB+1];
    logic [WW-1:0] dv_d_reg   [QB+1];
    logic [QB-1:0] dv_q_reg   [QB+1];
    logic          dv_v_reg   [QB+1];
    logic          dv_ok_reg  [QB+1];
    logic          dv_sat_reg [QB+1];
    logic [TA-1:0] dv_idx_reg [QB+1];
    logic [XW-1:0] dv_ds [1:QB];
    logic          dv_ge [1:QB];

    always_comb begin
        for (int k = 1; k <= QB; k++) begin
            dv_ds[k] = XW'(dv_d_reg[k-1]) << (QB - k);
            dv_ge[k] = dv_r_reg[k-1] >= dv_ds[k];
        end
    end

    always_ff @(posedge aclk) begin
        dv_r_reg[0]   <= s8_n_reg;
        dv_d_reg[0]   <= s8_d_reg;
        dv_q_reg[0]   <= '0;
        dv_ok_reg[0]  <= s8_ok_reg;
        dv_sat_reg[0] <= s8_n_reg >= (XW'(s8_d_reg) << QB);
        dv_idx_reg[0] <= s8_idx_reg;
        for (int k = 1; k <= QB; k++) begin
            dv_r_reg[k]   <= dv_ge[k] ? dv_r_reg[k-1] - dv_ds[k] : dv_r_reg[k-1];
            dv_d_reg[k]   <= dv_d_reg[k-1];
            dv_q_reg[k]   <= dv_q_reg[k-1] | (dv_ge[k] ? (QB'(1) << (QB - k)) : QB'(0));
            dv_ok_reg[k]  <= dv_ok_reg[k-1];
            dv_sat_reg[k] <= dv_sat_reg[k-1];
            dv_idx_reg[k] <= dv_idx_reg[k-1];
        end
    end

    // Valid bits of all stages.
    logic dv_any;

    always_comb begin
        dv_any = 1'b0;
        for (int k = 0; k <= QB; k++) begin
            dv_any = dv_any | dv_v_reg[k];
        end
    end

    assign pipe_busy = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg || s5_v_reg
                       || s6_v_reg || s7_v_reg || s8_v_reg || dv_any;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
            s8_v_reg <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                dv_v_reg[k] <= 1'b0;
            end
        end else begin
            s1_v_reg    <= issue;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            s6_v_reg    <= s5_v_reg;
            s7_v_reg    <= s6_v_reg;
            s8_v_reg    <= s7_v_reg;
            dv_v_reg[0] <= s8_v_reg;
            for (int k = 1; k <= QB; k++) begin
                dv_v_reg[k] <= dv_v_reg[k-1];
            end
        end
    end

    // Nearest hit tracking. A strictly smaller distance is needed to replace the
    // current best, so on a tie the earlier (lower) triangle stays.
    logic [31:0]   fin_t;
    logic          fin_take;
    logic          any_reg;
    logic [31:0]   best_t_reg;
    logic [TA-1:0] best_idx_reg;
    logic [16:0]   best_idx_ext;

    assign fin_t    = dv_sat_reg[QB] ? T_MAX : {1'b0, dv_q_reg[QB]};
    assign fin_take = dv_v_reg[QB] && dv_ok_reg[QB] && (!any_reg || fin_t < best_t_reg);
    assign best_idx_ext = 17'(best_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_reg <= 1'b0;
        end else if (s_acc && in_op == OP_CAST_RAY) begin
            any_reg <= 1'b0;
        end else if (fin_take) begin
            any_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_take) begin
            best_t_reg   <= fin_t;
            best_idx_reg <= dv_idx_reg[QB];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_hit_reg  <= any_reg;
            m_dist_reg <= any_reg ? best_t_reg : MISS_DIST;
            m_tri_reg  <= any_reg ? best_idx_ext[7:0] : 8'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_tri_reg, m_dist_reg};
    assign m_tuser  = m_hit_reg;

    `RMNH_ASSERT_IMPL(a_idle_pipe_empty, state_reg == ST_IDLE, !pipe_busy,
        "triangle pipeline still busy while idle")
    `RMNH_ASSERT_IMPL(a_issue_bound, state_reg == ST_RUN, iss_reg <= lim_reg,
        "triangle issue ran past the limit")
    `RMNH_ASSERT_IMPL(a_miss_value, m_tvalid_reg && !m_hit_reg,
        (m_dist_reg == MISS_DIST) && (m_tri_reg == 8'd0),
        "miss result carries a distance or index")
    `RMNH_ASSERT(a_result_after_finish, $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH),
        "result beat raised outside the finish state")

endmodule
